### rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants for the box pair collision block
// Field widths, axis codes, flag bit positions and the transaction structs
// that carry a box pair in and a resolved pair out.
// ----------------------------------------------------------------------------
package aabb_pkg;

	// Coordinate and size field widths.
	localparam int COORD_WIDTH = 24;
	localparam int SIZE_WIDTH  = 16;
	localparam int FLAG_WIDTH  = 4;
	localparam int AXIS_WIDTH  = 2;

	// Axis codes as reported on push_axis.
	localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

	// Bit positions inside pair_flags.
	localparam int FLAG_A_STATIC  = 0;
	localparam int FLAG_B_STATIC  = 1;
	localparam int FLAG_A_TRIGGER = 2;
	localparam int FLAG_B_TRIGGER = 3;

	// One box pair.
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] a_x;
		logic signed [COORD_WIDTH-1:0] a_y;
		logic signed [COORD_WIDTH-1:0] a_z;
		logic signed [COORD_WIDTH-1:0] b_x;
		logic signed [COORD_WIDTH-1:0] b_y;
		logic signed [COORD_WIDTH-1:0] b_z;
		logic [3*SIZE_WIDTH-1:0]       a_size;
		logic [3*SIZE_WIDTH-1:0]       b_size;
		logic [FLAG_WIDTH-1:0]         pair_flags;
	} pair_t;

	// One resolved pair.
	typedef struct packed {
		logic                          hit;
		logic                          pushed;
		logic [AXIS_WIDTH-1:0]         push_axis;
		logic signed [COORD_WIDTH-1:0] a_out_x;
		logic signed [COORD_WIDTH-1:0] a_out_y;
		logic signed [COORD_WIDTH-1:0] a_out_z;
		logic signed [COORD_WIDTH-1:0] b_out_x;
		logic signed [COORD_WIDTH-1:0] b_out_y;
		logic signed [COORD_WIDTH-1:0] b_out_z;
	} result_t;

endpackage

### rtl/aabb_collide_and_push_out.sv
// ----------------------------------------------------------------------------
// aabb_collide_and_push_out: box pair overlap test with push-out
// Tests two axis-aligned boxes for strict overlap and separates them along
// the axis of least penetration, with saturating anchor updates.
// ----------------------------------------------------------------------------
// Usage: present a box pair on pair with start high; busy never rises, so a
// transaction is taken on every cycle that start is high. Each result appears
// on result for exactly one cycle with done high, once the transaction has
// passed the input register, overlap register and result register, in the
// order the pairs went in. The receiver cannot stall the block, so
// results must be captured in the cycle that done is high. A new pair may be
// offered every cycle; throughput is one pair per clock.
module aabb_collide_and_push_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  aabb_pkg::pair_t   pair,
	output logic              done,
	output aabb_pkg::result_t result
);

	localparam int CW = aabb_pkg::COORD_WIDTH;
	localparam int SW = aabb_pkg::SIZE_WIDTH;
	// Doubled centre difference, overlap, move and push amount widths.
	localparam int DW = ((CW + 2 > SW + 1) ? CW + 2 : SW + 1) + 1;
	localparam int OW = DW + 1;
	localparam int MW = OW + 1;
	localparam int PW = OW - 1;

	// Stage 1: input register.
	logic            valid_s1;
	aabb_pkg::pair_t pair_s1;

	// Stage 2: overlap register.
	logic                   valid_s2;
	logic signed [CW-1:0]   a_s2 [3];
	logic signed [CW-1:0]   b_s2 [3];
	logic signed [OW-1:0]   o2_s2 [3];
	logic                   neg_s2 [3];
	logic [aabb_pkg::FLAG_WIDTH-1:0] flags_s2;

	// Stage 3: result register.
	logic              valid_s3;
	aabb_pkg::result_t result_s3;

	// Stage 1 unpacked values and stage 1 to 2 logic.
	logic signed [CW-1:0] a_c [3];
	logic signed [CW-1:0] b_c [3];
	logic signed [DW-1:0] sa_e [3];
	logic signed [DW-1:0] sb_e [3];
	logic signed [DW-1:0] c2 [3];
	logic signed [DW-1:0] c2_abs [3];
	logic signed [OW-1:0] o2 [3];

	// Stage 2 to 3 logic.
	logic                               hit;
	logic                               trig;
	logic                               push;
	logic [aabb_pkg::AXIS_WIDTH-1:0]    axis;
	logic signed [OW-1:0]               o2_sel;
	logic [PW-1:0]                      p;
	logic [PW-1:0]                      da;
	logic [PW-1:0]                      db;
	logic signed [MW-1:0]               da_e;
	logic signed [MW-1:0]               db_e;
	logic signed [CW-1:0]               a_mv [3];
	logic signed [CW-1:0]               b_mv [3];
	logic signed [CW-1:0]               a_new [3];
	logic signed [CW-1:0]               b_new [3];
	logic [aabb_pkg::AXIS_WIDTH-1:0]    axis_code [3];

	// Clamp a widened anchor to the signed coordinate range.
	function automatic logic signed [CW-1:0] sat_coord(input logic signed [MW-1:0] v);
		logic signed [CW-1:0] r;
		if ((&v[MW-1:CW-1]) || !(|v[MW-1:CW-1])) begin
			r = v[CW-1:0];
		end else if (v[MW-1]) begin
			r = {1'b1, {(CW-1){1'b0}}};
		end else begin
			r = {1'b0, {(CW-1){1'b1}}};
		end
		return r;
	endfunction

	// The block takes a transaction on every cycle.
	assign busy = 1'b0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pair_s1 <= pair;
		end
	end

	// Unpack anchors and sizes per axis.
	assign a_c[0] = pair_s1.a_x;
	assign a_c[1] = pair_s1.a_y;
	assign a_c[2] = pair_s1.a_z;
	assign b_c[0] = pair_s1.b_x;
	assign b_c[1] = pair_s1.b_y;
	assign b_c[2] = pair_s1.b_z;

	// Doubled centre difference and doubled overlap per axis; Y uses mid-height.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sa_e[k] = $signed({{(DW-SW){1'b0}}, pair_s1.a_size[k*SW +: SW]});
			sb_e[k] = $signed({{(DW-SW){1'b0}}, pair_s1.b_size[k*SW +: SW]});
			c2[k]   = (DW'(a_c[k]) - DW'(b_c[k])) <<< 1;
			if (k == 1) begin
				c2[k] = c2[k] + sa_e[k] - sb_e[k];
			end
			c2_abs[k] = c2[k][DW-1] ? -c2[k] : c2[k];
			o2[k]     = OW'(sa_e[k]) + OW'(sb_e[k]) - OW'(c2_abs[k]);
		end
	end

	// Overlap register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int k = 0; k < 3; k++) begin
				a_s2[k]   <= a_c[k];
				b_s2[k]   <= b_c[k];
				o2_s2[k]  <= o2[k];
				neg_s2[k] <= c2[k][DW-1];
			end
			flags_s2 <= pair_s1.pair_flags;
		end
	end

	// Hit test and axis of least penetration, X first on ties, then Z, then Y.
	assign hit  = (o2_s2[0] > 0) && (o2_s2[1] > 0) && (o2_s2[2] > 0);
	assign trig = flags_s2[aabb_pkg::FLAG_A_TRIGGER] || flags_s2[aabb_pkg::FLAG_B_TRIGGER];
	assign push = hit && !trig;

	always_comb begin
		if (!push) begin
			axis = aabb_pkg::AXIS_X;
		end else if ((o2_s2[0] <= o2_s2[1]) && (o2_s2[0] <= o2_s2[2])) begin
			axis = aabb_pkg::AXIS_X;
		end else if (o2_s2[2] <= o2_s2[1]) begin
			axis = aabb_pkg::AXIS_Z;
		end else begin
			axis = aabb_pkg::AXIS_Y;
		end
	end

	always_comb begin
		case (axis)
			aabb_pkg::AXIS_Y: o2_sel = o2_s2[1];
			aabb_pkg::AXIS_Z: o2_sel = o2_s2[2];
			default:          o2_sel = o2_s2[0];
		endcase
	end

	// Push amount: the full overlap for the free box, or half each.
	assign p = o2_sel[OW-1:1];

	always_comb begin
		if (flags_s2[aabb_pkg::FLAG_A_STATIC] && !flags_s2[aabb_pkg::FLAG_B_STATIC]) begin
			da = '0;
			db = p;
		end else if (flags_s2[aabb_pkg::FLAG_B_STATIC] && !flags_s2[aabb_pkg::FLAG_A_STATIC]) begin
			da = p;
			db = '0;
		end else begin
			da = p >> 1;
			db = p >> 1;
		end
	end

	assign da_e = $signed({{(MW-PW){1'b0}}, da});
	assign db_e = $signed({{(MW-PW){1'b0}}, db});

	assign axis_code[0] = aabb_pkg::AXIS_X;
	assign axis_code[1] = aabb_pkg::AXIS_Y;
	assign axis_code[2] = aabb_pkg::AXIS_Z;

	// Moved anchors per axis; A goes away from B, B the opposite way.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a_mv[k] = sat_coord(neg_s2[k] ? MW'(a_s2[k]) - da_e : MW'(a_s2[k]) + da_e);
			b_mv[k] = sat_coord(neg_s2[k] ? MW'(b_s2[k]) + db_e : MW'(b_s2[k]) - db_e);
			if (push && (axis == axis_code[k])) begin
				a_new[k] = a_mv[k];
				b_new[k] = b_mv[k];
			end else begin
				a_new[k] = a_s2[k];
				b_new[k] = b_s2[k];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			result_s3.hit       <= hit;
			result_s3.pushed    <= push;
			result_s3.push_axis <= axis;
			result_s3.a_out_x   <= a_new[0];
			result_s3.a_out_y   <= a_new[1];
			result_s3.a_out_z   <= a_new[2];
			result_s3.b_out_x   <= b_new[0];
			result_s3.b_out_y   <= b_new[1];
			result_s3.b_out_z   <= b_new[2];
		end
	end

	assign done   = valid_s3;
	assign result = result_s3;

	// Every accepted transaction yields a result once it has passed the input, overlap and result registers.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##2 done)
		else $error("accepted pair produced no result");

	// A push is only ever reported together with a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.pushed) |-> result.hit)
		else $error("push reported without hit");

	// Without a push the axis reads X and box A is returned unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.pushed) |-> (result.push_axis == aabb_pkg::AXIS_X)
			&& (result.a_out_x == $past(pair.a_x, 3))
			&& (result.a_out_y == $past(pair.a_y, 3))
			&& (result.a_out_z == $past(pair.a_z, 3)))
		else $error("anchor changed without push");

	// A push never uses an axis code beyond Z.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.push_axis == aabb_pkg::AXIS_X)
			|| (result.push_axis == aabb_pkg::AXIS_Y)
			|| (result.push_axis == aabb_pkg::AXIS_Z))
		else $error("invalid push axis");

endmodule
